@@ sv/ip2p_pkg.sv @@
// ----------------------------------------------------------------------------
// ip2p_pkg
// Shared types, character codes and helper functions for the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package ip2p_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned STK_CNT_W   = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h28;  // (
  localparam logic [7:0] CH_CLOSE = 8'h29;  // )
  localparam logic [7:0] CH_MUL   = 8'h2a;  // *
  localparam logic [7:0] CH_ADD   = 8'h2b;  // +
  localparam logic [7:0] CH_SUB   = 8'h2d;  // -
  localparam logic [7:0] CH_DIV   = 8'h2f;  // /
  localparam logic [7:0] CH_CARET = 8'h5e;  // ^

  typedef logic [1:0] prec_t;

  localparam prec_t PREC_NONE = 2'd0;
  localparam prec_t PREC_ADD  = 2'd1;
  localparam prec_t PREC_MUL  = 2'd2;
  localparam prec_t PREC_POW  = 2'd3;

  typedef enum logic [2:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OTHER
  } cls_e;

  typedef enum logic {
    PH_MAIN,
    PH_FLUSH
  } phase_e;

  typedef struct packed {
    logic [7:0] sym;
    cls_e       cls;
    prec_t      prec;
    logic       last;
  } q_item_t;

  function automatic prec_t prec_of(input logic [7:0] c);
    prec_t p;
    p = PREC_NONE;
    if (c == CH_ADD || c == CH_SUB) begin
      p = PREC_ADD;
    end else if (c == CH_MUL || c == CH_DIV) begin
      p = PREC_MUL;
    end else if (c == CH_CARET) begin
      p = PREC_POW;
    end
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic cls_e classify(input logic [7:0] c);
    cls_e k;
    if (is_alnum(c)) begin
      k = CLS_ALNUM;
    end else if (c == CH_OPEN) begin
      k = CLS_OPEN;
    end else if (c == CH_CLOSE) begin
      k = CLS_CLOSE;
    end else if (prec_of(c) != PREC_NONE) begin
      k = CLS_OPER;
    end else begin
      k = CLS_OTHER;
    end
    return k;
  endfunction

endpackage

@@ sv/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix conversion, one ASCII character per word.
// ----------------------------------------------------------------------------
// A letter or digit passes through the queue, then the output register.
// At most one push or pop per cycle. The stack engine takes one character
// at a time and dequeues it only when done; stack entries, including each
// '(' dropped in the flush, are popped in turn, and the terminator
// follows the flush pops. Ignored characters not marked last never reach it.
// Reset: empties the queue and the stack, clears the overflow flag; the
// stack memory contents are not cleared.
module infix_to_postfix_converter
  import ip2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       end_of_expression_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       has_symbol_o,
  output logic       expression_done_o,
  output logic       overflow_seen_o
);

  logic    item_valid, item_deq;
  q_item_t item;

  ip2p_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .symbol_i            (symbol_i),
    .end_of_expression_i (end_of_expression_i),
    .item_valid_o        (item_valid),
    .item_o              (item),
    .item_deq_i          (item_deq)
  );

  ip2p_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_valid),
    .item_i            (item),
    .item_deq_o        (item_deq),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_symbol_o      (out_symbol_o),
    .has_symbol_o      (has_symbol_o),
    .expression_done_o (expression_done_o),
    .overflow_seen_o   (overflow_seen_o)
  );

endmodule

@@ sv/ip2p_front.sv @@
// ----------------------------------------------------------------------------
// ip2p_front
// Accepts input words, classifies the character and queues it for the
// stack engine in a two-entry queue. Ignored characters not marked last
// are dropped here.
// ----------------------------------------------------------------------------
module ip2p_front
  import ip2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] symbol_i,
  input  logic       end_of_expression_i,
  output logic       item_valid_o,
  output q_item_t    item_o,
  input  logic       item_deq_i
);

  q_item_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       accept, keep, push, pop;
  q_item_t    new_item;

  always_comb begin
    new_item.sym  = symbol_i;
    new_item.cls  = classify(symbol_i);
    new_item.prec = prec_of(symbol_i);
    new_item.last = end_of_expression_i;
  end

  assign in_ready_o   = (fill_q != 2'd2);
  assign accept       = in_valid_i & in_ready_o;
  assign keep         = (new_item.cls != CLS_OTHER) | end_of_expression_i;
  assign push         = accept & keep;
  assign item_valid_o = (fill_q != 2'd0);
  assign pop          = item_deq_i & item_valid_o;
  assign item_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= new_item;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 2'd2)
    else $error("queue fill beyond two entries");

endmodule

@@ sv/ip2p_back.sv @@
// ----------------------------------------------------------------------------
// ip2p_back
// Stack engine: runs the shunting-yard rules on one queued character at a
// time, at most one push or pop per cycle, and drives the output register.
// ----------------------------------------------------------------------------
module ip2p_back
  import ip2p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  q_item_t    item_i,
  output logic       item_deq_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_symbol_o,
  output logic       has_symbol_o,
  output logic       expression_done_o,
  output logic       overflow_seen_o
);

  logic [7:0]           mem_q [STACK_DEPTH];
  logic [7:0]           top_q, rd_q;
  logic                 top_from_rd_q;
  logic [STK_CNT_W-1:0] count_q;
  logic                 ovf_q;
  phase_e               ph_q, ph_d;

  logic                 out_valid_q, out_has_q, out_done_q, out_ovf_q;
  logic [7:0]           out_sym_q;

  logic [7:0]           top;
  prec_t                top_prec;
  logic                 nonempty, full, can_emit;
  logic                 do_emit, emit_has, do_push, do_pop, ovf_clr;
  logic [7:0]           emit_sym;
  logic [STK_IDX_W-1:0] rd_addr, wr_addr;
  logic [STK_CNT_W-1:0] cnt_m2;

  assign top      = top_from_rd_q ? rd_q : top_q;
  assign top_prec = prec_of(top);
  assign nonempty = (count_q != '0);
  assign full     = (count_q >= STK_CNT_W'(STACK_DEPTH));
  assign can_emit = ~out_valid_q | out_ready_i;
  assign cnt_m2   = count_q - STK_CNT_W'(2);
  assign rd_addr  = cnt_m2[STK_IDX_W-1:0];
  assign wr_addr  = count_q[STK_IDX_W-1:0];

  always_comb begin
    do_emit    = 1'b0;
    emit_sym   = 8'h00;
    emit_has   = 1'b1;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    ovf_clr    = 1'b0;
    item_deq_o = 1'b0;
    ph_d       = ph_q;
    unique case (ph_q)
      PH_MAIN: begin
        if (item_valid_i) begin
          unique case (item_i.cls)
            CLS_ALNUM: begin
              if (can_emit) begin
                do_emit  = 1'b1;
                emit_sym = item_i.sym;
                if (item_i.last) ph_d = PH_FLUSH;
                else item_deq_o = 1'b1;
              end
            end
            CLS_OPEN: begin
              do_push = 1'b1;
              if (item_i.last) ph_d = PH_FLUSH;
              else item_deq_o = 1'b1;
            end
            CLS_CLOSE: begin
              if (nonempty && top != CH_OPEN) begin
                if (can_emit) begin
                  do_emit  = 1'b1;
                  emit_sym = top;
                  do_pop   = 1'b1;
                end
              end else begin
                do_pop = nonempty;
                if (item_i.last) ph_d = PH_FLUSH;
                else item_deq_o = 1'b1;
              end
            end
            CLS_OPER: begin
              if (nonempty && (top_prec > item_i.prec ||
                  (top_prec == item_i.prec && item_i.sym != CH_CARET))) begin
                if (can_emit) begin
                  do_emit  = 1'b1;
                  emit_sym = top;
                  do_pop   = 1'b1;
                end
              end else begin
                do_push = 1'b1;
                if (item_i.last) ph_d = PH_FLUSH;
                else item_deq_o = 1'b1;
              end
            end
            default: begin
              if (item_i.last) ph_d = PH_FLUSH;
              else item_deq_o = 1'b1;
            end
          endcase
        end
      end
      PH_FLUSH: begin
        if (nonempty) begin
          if (top == CH_OPEN) begin
            do_pop = 1'b1;
          end else if (can_emit) begin
            do_emit  = 1'b1;
            emit_sym = top;
            do_pop   = 1'b1;
          end
        end else if (can_emit) begin
          do_emit    = 1'b1;
          emit_has   = 1'b0;
          ovf_clr    = 1'b1;
          item_deq_o = 1'b1;
          ph_d       = PH_MAIN;
        end
      end
      default: ph_d = PH_MAIN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q          <= PH_MAIN;
      count_q       <= '0;
      ovf_q         <= 1'b0;
      top_from_rd_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      ph_q <= ph_d;
      if (do_push) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q       <= count_q + STK_CNT_W'(1);
          top_from_rd_q <= 1'b0;
        end
      end else if (do_pop) begin
        count_q       <= count_q - STK_CNT_W'(1);
        top_from_rd_q <= 1'b1;
      end
      if (ovf_clr) ovf_q <= 1'b0;
      if (do_emit)          out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push && !full) begin
      mem_q[wr_addr] <= item_i.sym;
      top_q          <= item_i.sym;
    end
    if (do_pop) rd_q <= mem_q[rd_addr];
    if (do_emit) begin
      out_sym_q  <= emit_sym;
      out_has_q  <= emit_has;
      out_done_q <= ~emit_has;
      out_ovf_q  <= ~emit_has & ovf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_symbol_o      = out_sym_q;
  assign has_symbol_o      = out_has_q;
  assign expression_done_o = out_done_q;
  assign overflow_seen_o   = out_ovf_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= STK_CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_term_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_emit && !emit_has) |-> (count_q == '0))
    else $error("terminator with operators still stacked");

  a_ovf_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_clr |=> !ovf_q)
    else $error("overflow flag not cleared after terminator");

  a_no_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_push && do_pop))
    else $error("push and pop in the same cycle");

endmodule
